FILE: sv/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

    typedef logic [1:0] result_kind_t;

    localparam result_kind_t KIND_NOT_PRIME = 2'd0;
    localparam result_kind_t KIND_PRIME     = 2'd1;
    localparam result_kind_t KIND_FACTOR2   = 2'd2;
    localparam result_kind_t KIND_FACTOR_D  = 2'd3;

    localparam int FACTOR_WIDTH = 30;

    typedef struct packed {
        logic         load;
        logic         div_start;
        logic         div_step;
        logic         advance;
        logic         emit;
        result_kind_t kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic below_two;
        logic is_two;
        logic is_even;
        logic sq_above;
        logic div_last;
        logic rem_zero;
    } dp_stat_t;

endpackage

FILE: sv/trial_division_prime_test.sv
`timescale 1ns / 1ps
// Trial-division primality test.
// Request: drive candidate and raise start while busy is low; the request is
// taken at that clock edge and busy stays high until the answer is issued.
// Answer: done pulses high for one cycle with is_prime and smallest_factor
// (0 when prime or below two). The receiver cannot stall: the answer is
// valid for that one cycle only, and a new start is taken the cycle after
// busy falls, which may coincide with done.
// Flow: candidates below two, two, and even numbers are answered straight
// from the classify state. An odd candidate is tried against the odd
// divisors 3, 5, ... in turn, up to its smallest factor or up to the
// square root. Each divisor costs one radix-2 remainder pass, one step per
// bit of NUMBER_WIDTH, plus a bound check and a remainder check; the bound
// uses a running square of the divisor, so no multiplier is needed.
// One request is worked at a time.
// Reset: rst_n is asynchronous, active low; the block returns to idle with
// busy and done low.
module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] candidate,
    output logic        busy,
    output logic        done,
    output logic        is_prime,
    output logic [tdpt_pkg::FACTOR_WIDTH-1:0] smallest_factor
);
    import tdpt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    tdpt_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tdpt_datapath #(
        .NW (NUMBER_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .candidate       (candidate),
        .cmd             (cmd),
        .stat            (stat),
        .done            (done),
        .is_prime        (is_prime),
        .smallest_factor (smallest_factor)
    );

endmodule

FILE: sv/tdpt_datapath.sv
`timescale 1ns / 1ps

module tdpt_datapath #(
    parameter int NW = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [30:0]                    candidate,
    input  tdpt_pkg::ctrl_cmd_t            cmd,
    output tdpt_pkg::dp_stat_t             stat,
    output logic                           done,
    output logic                           is_prime,
    output logic [tdpt_pkg::FACTOR_WIDTH-1:0] smallest_factor
);
    import tdpt_pkg::*;

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;
    localparam int SW = NW + 2;

    logic [NW-1:0] n_reg;
    logic [NW-1:0] d_reg;
    logic [SW-1:0] sq_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] sh_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          prime_reg;
    logic [FACTOR_WIDTH-1:0] factor_reg;

    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic [NW-1:0] rem_next;
    logic [SW-1:0] sq_next;

    assign trial    = {rem_reg, sh_reg[NW-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign rem_next = (trial >= {1'b0, d_reg}) ? diff[NW-1:0] : trial[NW-1:0];
    assign sq_next  = sq_reg + {d_reg, 2'b00} + SW'(4);

    assign stat.below_two = (n_reg < NW'(2));
    assign stat.is_two    = (n_reg == NW'(2));
    assign stat.is_even   = ~n_reg[0];
    assign stat.sq_above  = (sq_reg > {2'b00, n_reg});
    assign stat.div_last  = (cnt_reg == CW'(NW - 1));
    assign stat.rem_zero  = (rem_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg  <= NW'(candidate);
            d_reg  <= NW'(3);
            sq_reg <= SW'(9);
        end
        else if (cmd.advance)
        begin
            d_reg  <= d_reg + NW'(2);
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            sh_reg  <= n_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[NW-2:0], 1'b0};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.kind)
                KIND_PRIME:
                begin
                    prime_reg  <= 1'b1;
                    factor_reg <= '0;
                end
                KIND_FACTOR2:
                begin
                    prime_reg  <= 1'b0;
                    factor_reg <= FACTOR_WIDTH'(2);
                end
                KIND_FACTOR_D:
                begin
                    prime_reg  <= 1'b0;
                    factor_reg <= FACTOR_WIDTH'(d_reg);
                end
                default:
                begin
                    prime_reg  <= 1'b0;
                    factor_reg <= '0;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign is_prime        = prime_reg;
    assign smallest_factor = factor_reg;

endmodule

FILE: sv/tdpt_controller.sv
`timescale 1ns / 1ps

module tdpt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tdpt_pkg::dp_stat_t  stat,
    output tdpt_pkg::ctrl_cmd_t cmd,
    output logic                busy
);
    import tdpt_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLASSIFY = 3'd1;
    localparam logic [2:0] ST_TEST     = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_CHECK    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_NOT_PRIME;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (stat.below_two)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_NOT_PRIME;
                    state_next = ST_IDLE;
                end
                else if (stat.is_two)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_PRIME;
                    state_next = ST_IDLE;
                end
                else if (stat.is_even)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_FACTOR2;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (stat.sq_above)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_PRIME;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.rem_zero)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_FACTOR_D;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_TEST;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
